// ===== hdl/sbat_pkg.sv =====
// Package with the types and constants of the slot allocator.
package sbat_pkg;
	localparam int SLOTS = 256;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [2:0] OP_ALLOC  = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_SELECT = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] uid_low;
		logic [63:0] uid_high;
		logic [7:0]  slot_index;
		logic [7:0]  rank;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] slot;
		logic [8:0] occupied_count;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input word, clear scan pointer
		logic step;       // examine one slot, advance pointer
		logic do_alloc;   // mark scan slot occupied, write identifier
		logic do_delete;  // free slot_index
		logic do_clear;   // free all slots
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              hit;       // current scan slot satisfies the operation
		logic              last;      // current scan slot is the final one
		logic              empty;
		logic              full;
		logic              del_ok;    // delete target is occupied
		logic [SLOT_W-1:0] del_slot;  // delete target
		logic [2:0]        opcode;
	} stat_t;
endpackage

// ===== hdl/sbat_datapath.sv =====
// Datapath: occupancy bits, identifier memory, count and the slot scan.
module sbat_datapath
	import sbat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  cmd_t      cmd,
	output stat_t     stat,
	output logic [SLOT_W-1:0] ptr,
	output logic [CNT_W-1:0]  count
);
	logic [SLOTS-1:0]  occ_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W:0]   seen_q;
	in_word_t          req_q;
	logic [127:0]      uid_mem [SLOTS];
	logic [127:0]      rd_q;
	logic              occ_cur;
	logic              hit;

	// The identifier read for slot ptr is registered; the controller passes through
	// S_WAIT after each pointer move before sampling the hit flag in S_TEST.
	always_ff @(posedge clk) begin
		rd_q <= uid_mem[ptr_q];
		if (cmd.do_alloc) begin
			uid_mem[ptr_q] <= {req_q.uid_high, req_q.uid_low};
		end
	end

	assign occ_cur = occ_q[ptr_q];

	always_comb begin
		case (req_q.opcode)
			OP_ALLOC:  hit = !occ_cur;
			OP_LOOKUP: hit = occ_cur && (rd_q == {req_q.uid_high, req_q.uid_low});
			OP_SELECT: hit = occ_cur && (seen_q == {1'b0, req_q.rank});
			default:   hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			seen_q  <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q  <= '0;
				seen_q <= '0;
			end else if (cmd.step) begin
				ptr_q <= ptr_q + 1'b1;
				if (occ_cur) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (cmd.do_alloc) begin
				occ_q[ptr_q] <= 1'b1;
				count_q      <= count_q + 1'b1;
			end else if (cmd.do_delete) begin
				occ_q[req_q.slot_index[SLOT_W-1:0]] <= 1'b0;
				count_q <= count_q - 1'b1;
			end else if (cmd.do_clear) begin
				occ_q   <= '0;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_word;
		end
	end

	assign stat.hit      = hit;
	assign stat.last     = (ptr_q == SLOT_W'(SLOTS - 1));
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(SLOTS));
	assign stat.del_ok   = occ_q[req_q.slot_index[SLOT_W-1:0]];
	assign stat.del_slot = req_q.slot_index[SLOT_W-1:0];
	assign stat.opcode   = req_q.opcode;
	assign ptr   = ptr_q;
	assign count = count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_alloc |-> !occ_cur)
		else $error("allocate into an occupied slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_delete |-> occ_q[req_q.slot_index[SLOT_W-1:0]] && count_q != '0)
		else $error("delete of a free slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("occupied count overflow");
endmodule

// ===== hdl/sbat_ctrl.sv =====
// Controller: sequences one word through decode, scan and result.
module sbat_ctrl
	import sbat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  stat_t     stat,
	input  logic [SLOT_W-1:0] ptr,
	input  logic [CNT_W-1:0]  count,
	output cmd_t      cmd,
	output out_word_t out_word
);
	typedef enum logic [2:0] {S_IDLE, S_DEC, S_WAIT, S_TEST, S_FIN, S_OUT} state_t;
	state_t     state_q;
	logic [1:0] st_q;
	logic [7:0] slot_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		if (state_q == S_DEC) begin
			cmd.do_delete = (stat.opcode == OP_DELETE) && !stat.empty
				&& stat.del_ok;
			cmd.do_clear  = (stat.opcode == OP_CLEAR);
		end
		if (state_q == S_TEST) begin
			cmd.do_alloc = stat.hit && (stat.opcode == OP_ALLOC);
			cmd.step     = !stat.hit && !stat.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			st_q      <= ST_OK;
			slot_q    <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (stat.opcode) inside
						OP_ALLOC: begin
							slot_q <= '0;
							if (stat.full) begin
								st_q    <= ST_FULL;
								state_q <= S_FIN;
							end else begin
								st_q    <= ST_OK;
								state_q <= S_WAIT;
							end
						end
						OP_DELETE: begin
							state_q <= S_FIN;
							if (stat.empty) begin
								st_q   <= ST_EMPTY;
								slot_q <= '0;
							end else if (!stat.del_ok) begin
								st_q   <= ST_MISS;
								slot_q <= '0;
							end else begin
								st_q   <= ST_OK;
								slot_q <= 8'(stat.del_slot);
							end
						end
						OP_LOOKUP, OP_SELECT: begin
							slot_q <= '0;
							if (stat.empty) begin
								st_q    <= ST_MISS;
								state_q <= S_FIN;
							end else begin
								st_q    <= ST_OK;
								state_q <= S_WAIT;
							end
						end
						default: begin
							st_q    <= ST_OK;
							slot_q  <= '0;
							state_q <= S_FIN;
						end
					endcase
				end
				S_WAIT: state_q <= S_TEST;
				S_TEST: begin
					if (stat.hit) begin
						slot_q  <= 8'(ptr);
						state_q <= S_FIN;
					end else if (stat.last) begin
						st_q    <= ST_MISS;
						state_q <= S_FIN;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_word.status         = st_q;
	assign out_word.slot           = slot_q;
	assign out_word.occupied_count = 9'(count);

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("new word taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_alloc, cmd.do_delete, cmd.do_clear}))
		else $error("conflicting update commands");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.status == ST_OK || out_word.slot == '0))
		else $error("nonzero slot with error status");
endmodule

// ===== hdl/slot_bitmap_allocator_uid_table_unit.sv =====
// Top level of the slot allocator with identifier match.
// One word in gives one word out. Delete, clear and unused opcodes go from decode
// to the finish and output states; allocate, lookup and select scan the slots in
// ascending order, unless allocate finds them all full or lookup and select find
// them empty; each slot gets a registered identifier memory read, then a compare.
// A new word is taken only after the previous result has been delivered.
module slot_bitmap_allocator_uid_table_unit
	import sbat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);
	cmd_t  cmd;
	stat_t stat;
	logic [SLOT_W-1:0] ptr;
	logic [CNT_W-1:0]  count;

	sbat_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_data), .cmd(cmd),
		.stat(stat), .ptr(ptr), .count(count)
	);

	sbat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ptr(ptr),
		.count(count), .cmd(cmd), .out_word(out_data)
	);
endmodule
